// ===== rtl/srca_pkg.sv =====
`default_nettype none

package srca_pkg;

  // coordinate width, two's complement fixed point (default Q16.16)
  localparam int CW = 32;
  // split point of the multiplier operand into partial products
  localparam int HW = CW / 2;

  typedef enum logic [1:0] {
    KIND_OVERLAP,
    KIND_MISS,
    KIND_CONTACT
  } kind_t;

  // input beat
  typedef struct packed {
    logic signed [CW-1:0] mover_left;
    logic signed [CW-1:0] mover_right;
    logic signed [CW-1:0] mover_bottom;
    logic signed [CW-1:0] mover_top;
    logic signed [CW-1:0] obstacle_left;
    logic signed [CW-1:0] obstacle_right;
    logic signed [CW-1:0] obstacle_bottom;
    logic signed [CW-1:0] obstacle_top;
    logic signed [CW-1:0] move_x;
    logic signed [CW-1:0] move_y;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic                 collides;
    logic signed [CW-1:0] allowed_x;
    logic signed [CW-1:0] allowed_y;
  } out_beat_t;

  // divider state handed from cell to cell
  typedef struct packed {
    logic [CW-1:0] rem;
    logic [CW-1:0] num_lo;
    logic [CW-1:0] quo;
    logic [CW-1:0] den;
  } div_t;

  // side data riding along with the divider state
  typedef struct packed {
    kind_t                kind;
    logic                 ovf;
    logic                 div_x;
    logic [CW-1:0]        fixed;
    logic signed [CW-1:0] move_x;
    logic signed [CW-1:0] move_y;
  } side_t;

  // clamp a magnitude into the signed range and apply the sign
  function automatic logic [CW-1:0] sat_signed(input logic [CW-1:0] mag, input logic neg);
    logic [CW-1:0] lim;
    logic [CW-1:0] pmax;
    logic [CW-1:0] m;
    lim  = {1'b1, {(CW-1){1'b0}}};
    pmax = {1'b0, {(CW-1){1'b1}}};
    if (neg) begin
      m = (mag > lim) ? lim : mag;
      sat_signed = -m;
    end else begin
      m = (mag > pmax) ? pmax : mag;
      sat_signed = m;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srca_prep.sv =====
`default_nettype none

module srca_prep (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire srca_pkg::in_beat_t in_beat,
  output logic                 out_valid,
  output srca_pkg::div_t       out_div,
  output srca_pkg::side_t      out_side
);
  import srca_pkg::*;

  typedef struct packed {
    kind_t                kind;
    logic signed [CW-1:0] mx;
    logic signed [CW-1:0] my;
    logic [CW-1:0]        dx;
    logic [CW-1:0]        dy;
    logic [CW-1:0]        ax;
    logic [CW-1:0]        ay;
  } geo_t;

  geo_t s1, s1_next, s2, s3;
  logic [CW+HW-1:0]   pl_lo, pr_lo;
  logic [2*CW-HW-1:0] pl_hi, pr_hi;
  logic [2*CW-1:0]    lprod, rprod;
  logic               v1, v2, v3;

  logic signed [CW:0] ml, mr, mb, mt, ol, orr, ob, ot, mx, my;
  logic signed [CW:0] nl, nr, nb, nt;
  logic               now_x, now_y, mov_x, mov_y;
  logic signed [CW:0] gx, gy;

  // stage one: overlap tests, gaps and magnitudes
  always_comb begin
    ml  = {in_beat.mover_left[CW-1], in_beat.mover_left};
    mr  = {in_beat.mover_right[CW-1], in_beat.mover_right};
    mb  = {in_beat.mover_bottom[CW-1], in_beat.mover_bottom};
    mt  = {in_beat.mover_top[CW-1], in_beat.mover_top};
    ol  = {in_beat.obstacle_left[CW-1], in_beat.obstacle_left};
    orr = {in_beat.obstacle_right[CW-1], in_beat.obstacle_right};
    ob  = {in_beat.obstacle_bottom[CW-1], in_beat.obstacle_bottom};
    ot  = {in_beat.obstacle_top[CW-1], in_beat.obstacle_top};
    mx  = {in_beat.move_x[CW-1], in_beat.move_x};
    my  = {in_beat.move_y[CW-1], in_beat.move_y};
    nl  = ml + mx;
    nr  = mr + mx;
    nb  = mb + my;
    nt  = mt + my;
    now_x = !(ml > orr || mr < ol);
    now_y = !(mb > ot || mt < ob);
    mov_x = !(nl > orr || nr < ol);
    mov_y = !(nb > ot || nt < ob);
    if (ml > orr)      gx = ml - orr;
    else if (mr < ol)  gx = ol - mr;
    else               gx = '0;
    if (mb > ot)       gy = mb - ot;
    else if (mt < ob)  gy = ob - mt;
    else               gy = '0;
    s1_next.mx = in_beat.move_x;
    s1_next.my = in_beat.move_y;
    s1_next.dx = gx[CW-1:0];
    s1_next.dy = gy[CW-1:0];
    s1_next.ax = in_beat.move_x[CW-1] ? -in_beat.move_x : in_beat.move_x;
    s1_next.ay = in_beat.move_y[CW-1] ? -in_beat.move_y : in_beat.move_y;
    if (now_x && now_y)      s1_next.kind = KIND_OVERLAP;
    else if (mov_x && mov_y) s1_next.kind = KIND_CONTACT;
    else                     s1_next.kind = KIND_MISS;
  end

  // stage two: partial products of both cross terms
  always_ff @(posedge clk) begin
    s1    <= s1_next;
    s2    <= s1;
    pl_lo <= {{HW{1'b0}}, s1.dx} * {{CW{1'b0}}, s1.ay[HW-1:0]};
    pl_hi <= {{HW{1'b0}}, s1.dx} * {{CW{1'b0}}, s1.ay[CW-1:HW]};
    pr_lo <= {{HW{1'b0}}, s1.ax} * {{CW{1'b0}}, s1.dy[HW-1:0]};
    pr_hi <= {{HW{1'b0}}, s1.ax} * {{CW{1'b0}}, s1.dy[CW-1:HW]};
  end

  // stage three: sum partial products
  always_ff @(posedge clk) begin
    s3    <= s2;
    lprod <= {{(CW-HW){1'b0}}, pl_lo} + {pl_hi, {HW{1'b0}}};
    rprod <= {{(CW-HW){1'b0}}, pr_lo} + {pr_hi, {HW{1'b0}}};
  end

  // stage four: pick the axis hit last and set up the division
  logic          gt, ovf_l, ovf_r;
  div_t          div_next;
  side_t         side_next;
  logic [2*CW-1:0] num;

  always_comb begin
    gt    = lprod > rprod;
    ovf_l = lprod[2*CW-1:CW] >= s3.ax;
    ovf_r = rprod[2*CW-1:CW] >= s3.ay;
    side_next.kind   = s3.kind;
    side_next.move_x = s3.mx;
    side_next.move_y = s3.my;
    if (gt) begin
      num            = lprod;
      div_next.den   = s3.ax;
      side_next.ovf  = ovf_l;
      side_next.div_x = 1'b0;
      side_next.fixed = s3.dx;
    end else if (s3.ay == '0) begin
      // no y motion: x stops at the gap, done as gap over one
      num            = {{CW{1'b0}}, s3.dx};
      div_next.den   = {{(CW-1){1'b0}}, 1'b1};
      side_next.ovf  = 1'b0;
      side_next.div_x = 1'b1;
      side_next.fixed = s3.dy;
    end else begin
      num            = rprod;
      div_next.den   = s3.ay;
      side_next.ovf  = ovf_r;
      side_next.div_x = 1'b1;
      side_next.fixed = s3.dy;
    end
    div_next.rem    = side_next.ovf ? '0 : num[2*CW-1:CW];
    div_next.num_lo = num[CW-1:0];
    div_next.quo    = '0;
  end

  always_ff @(posedge clk) begin
    out_div  <= div_next;
    out_side <= side_next;
  end

  // beat valid through the four stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srca_div_cell.sv =====
`default_nettype none

module srca_div_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire srca_pkg::div_t   in_div,
  input  wire srca_pkg::side_t  in_side,
  output logic                  out_valid,
  output srca_pkg::div_t        out_div,
  output srca_pkg::side_t       out_side
);
  import srca_pkg::*;

  logic [CW:0] r2, diff;
  logic        ge;
  div_t        div_next;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    r2   = {in_div.rem, in_div.num_lo[CW-1]};
    diff = r2 - {1'b0, in_div.den};
    ge   = r2 >= {1'b0, in_div.den};
    div_next.rem    = ge ? diff[CW-1:0] : r2[CW-1:0];
    div_next.num_lo = {in_div.num_lo[CW-2:0], 1'b0};
    div_next.quo    = {in_div.quo[CW-2:0], ge};
    div_next.den    = in_div.den;
  end

  always_ff @(posedge clk) begin
    out_div  <= div_next;
    out_side <= in_side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swept_rect_collision_adjust.sv =====
`default_nettype none

// Swept collision adjust for two axis-aligned rectangles.
// Input: a beat on item is taken at each clock edge where start is high and
// busy is low. busy stays low, so a new beat may be offered every cycle.
// Output: each beat yields exactly one result on result, marked by done for
// a single cycle; the receiver cannot stall and must take it then.
// Path: an accepted beat passes the overlap and gap tests, the
// partial-product multiply, the partial-product sum, the axis select, CW
// cells of the divider chain (one quotient bit per cell, CW being 32 by
// default) and one output register, each registered. Throughput is one
// beat per cycle; every beat flows through the chain alongside the others.
// Results: overlap now gives collides with zero motion; a miss passes the
// displacement unchanged; a contact shortens the motion to first contact,
// saturated to the signed coordinate range.
// Reset: synchronous rst drops every in-flight beat; no result is issued
// for beats taken before reset.
module swept_rect_collision_adjust (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire srca_pkg::in_beat_t  item,
  output logic                     done,
  output srca_pkg::out_beat_t      result
);
  import srca_pkg::*;

  localparam int LAT = CW + 5;

  logic  vchain [CW+1];
  div_t  dchain [CW+1];
  side_t schain [CW+1];

  assign busy = 1'b0;

  // front stages
  srca_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_beat  (item),
    .out_valid(vchain[0]),
    .out_div  (dchain[0]),
    .out_side (schain[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < CW; i++) begin : g_cell
    srca_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vchain[i]),
      .in_div   (dchain[i]),
      .in_side  (schain[i]),
      .out_valid(vchain[i+1]),
      .out_div  (dchain[i+1]),
      .out_side (schain[i+1])
    );
  end

  // final select, sign and saturation
  side_t         tail;
  logic [CW-1:0] mag_q, mag_x, mag_y;
  out_beat_t     result_next;

  always_comb begin
    tail  = schain[CW];
    mag_q = tail.ovf ? '1 : dchain[CW].quo;
    mag_x = tail.div_x ? mag_q : tail.fixed;
    mag_y = tail.div_x ? tail.fixed : mag_q;
    case (tail.kind)
      KIND_OVERLAP: begin
        result_next.collides  = 1'b1;
        result_next.allowed_x = '0;
        result_next.allowed_y = '0;
      end
      KIND_CONTACT: begin
        result_next.collides  = 1'b1;
        result_next.allowed_x = sat_signed(mag_x, tail.move_x[CW-1]);
        result_next.allowed_y = sat_signed(mag_y, tail.move_y[CW-1]);
      end
      default: begin
        result_next.collides  = 1'b0;
        result_next.allowed_x = tail.move_x;
        result_next.allowed_y = tail.move_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vchain[CW];
    end
  end

  // every result traces back to a beat taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching input beat");

  // a miss hands the displacement back untouched
  a_pass: assert property (@(posedge clk) disable iff (rst)
    done && !result.collides |->
      result.allowed_x == $past(item.move_x, LAT) &&
      result.allowed_y == $past(item.move_y, LAT))
    else $error("miss result does not pass the displacement");

  // a nonzero adjusted x motion keeps the direction of the request
  a_sign: assert property (@(posedge clk) disable iff (rst)
    done && result.allowed_x != '0 |->
      result.allowed_x[CW-1] == $past(item.move_x[CW-1], LAT))
    else $error("adjusted x motion changed direction");

endmodule

`default_nettype wire
